// ===== rtl/ddma_pkg.sv =====
package ddma_pkg;

   // field widths
   localparam int SAMPLE_W  = 12;
   localparam int TOTAL_W   = 16;
   localparam int CFG_W     = 16;
   localparam int VOLT_W    = 24;
   localparam int DENSITY_W = 24;

   // window length
   localparam int WINDOW_DEFAULT = 10;
   localparam int WINDOW_MAX     = 16;

   // reciprocal precision for the divide by the window length
   localparam int RECIP_SHIFT = 20;

   // register map
   localparam int          CSR_ADDR_W   = 4;
   localparam int          CSR_DATA_W   = 32;
   localparam logic [1:0]  REG_NO_DUST  = 2'd0;
   localparam logic [1:0]  REG_RATIO    = 2'd1;
   localparam logic [1:0]  REG_FULL_SCL = 2'd2;

   localparam logic [CFG_W-1:0] NO_DUST_RESET  = 16'd400;
   localparam logic [CFG_W-1:0] RATIO_RESET    = 16'd13107;
   localparam logic [CFG_W-1:0] FULL_SCL_RESET = 16'd36300;

   typedef struct packed {
      logic accept;
      logic div;
      logic corr;
      logic volt;
      logic load;
   } ctrl_cmd_type;

endpackage

// ===== rtl/ddma_ctrl.sv =====
module ddma_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ddma_pkg::ctrl_cmd_type cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_CORR = 3'd2;
   localparam logic [2:0] ST_VOLT = 3'd3;
   localparam logic [2:0] ST_DENS = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;
   logic       can_accept;
   logic       accept;
   logic       load;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   // a new beat may enter while the last one leaves the final step
   assign can_accept = (state_ff == ST_IDLE) || ((state_ff == ST_DENS) && out_free);
   assign req_stall  = reset || !can_accept;
   assign accept     = req_valid && !req_stall;
   assign load       = (state_ff == ST_DENS) && out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_DIV;
         end
         ST_DIV:  state_in = ST_CORR;
         ST_CORR: state_in = ST_VOLT;
         ST_VOLT: state_in = ST_DENS;
         ST_DENS: begin
            if (load) state_in = accept ? ST_DIV : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign cmd.accept = accept;
   assign cmd.div    = (state_ff == ST_DIV);
   assign cmd.corr   = (state_ff == ST_CORR);
   assign cmd.volt   = (state_ff == ST_VOLT);
   assign cmd.load   = load;

endmodule

// ===== rtl/ddma_dpath.sv =====
module ddma_dpath #(
   parameter int WINDOW = ddma_pkg::WINDOW_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  ddma_pkg::ctrl_cmd_type           cmd,
   input  logic [ddma_pkg::SAMPLE_W-1:0]    req_sample,
   input  logic [ddma_pkg::CFG_W-1:0]       no_dust_mv,
   input  logic [ddma_pkg::CFG_W-1:0]       ratio_q16,
   input  logic [ddma_pkg::CFG_W-1:0]       full_scale_mv,
   output logic [ddma_pkg::DENSITY_W-1:0]   rsp_density_q8,
   output logic [ddma_pkg::SAMPLE_W-1:0]    rsp_average
);

   localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int RECIP_W = ddma_pkg::RECIP_SHIFT + 1;
   localparam int PROD_W  = ddma_pkg::TOTAL_W + RECIP_W;
   localparam int REM_W   = ddma_pkg::TOTAL_W + 1;
   localparam int VPROD_W = ddma_pkg::SAMPLE_W + ddma_pkg::CFG_W;
   localparam int DPROD_W = ddma_pkg::VOLT_W + ddma_pkg::CFG_W;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << ddma_pkg::RECIP_SHIFT) / WINDOW);
   localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(WINDOW - 1);

   logic [ddma_pkg::SAMPLE_W-1:0]  ring_ff [WINDOW];
   logic [SLOT_W-1:0]              slot_ff;
   logic [SLOT_W-1:0]              slot_in;
   logic [ddma_pkg::TOTAL_W-1:0]   total_ff;
   logic [ddma_pkg::TOTAL_W-1:0]   total_in;
   logic [ddma_pkg::SAMPLE_W-1:0]  qest_ff;
   logic [ddma_pkg::SAMPLE_W-1:0]  qest_in;
   logic [ddma_pkg::SAMPLE_W-1:0]  avg_ff;
   logic [ddma_pkg::SAMPLE_W-1:0]  avg_in;
   logic [ddma_pkg::VOLT_W-1:0]    volt_ff;
   logic [ddma_pkg::VOLT_W-1:0]    volt_in;
   logic [ddma_pkg::DENSITY_W-1:0] density_ff;
   logic [ddma_pkg::DENSITY_W-1:0] density_in;
   logic [ddma_pkg::SAMPLE_W-1:0]  average_ff;
   logic [PROD_W-1:0]              recip_prod;
   logic [REM_W-1:0]               rem;
   logic [VPROD_W-1:0]             volt_prod;
   logic [ddma_pkg::VOLT_W-1:0]    floor_q8;
   logic [ddma_pkg::VOLT_W-1:0]    diff;
   logic [DPROD_W-1:0]             dens_prod;

   // ring update and running sum on accept
   assign total_in = total_ff - ddma_pkg::TOTAL_W'(ring_ff[slot_ff])
                   + ddma_pkg::TOTAL_W'(req_sample);
   assign slot_in  = (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW; i++) ring_ff[i] <= '0;
         total_ff <= '0;
         slot_ff  <= '0;
      end else if (cmd.accept) begin
         ring_ff[slot_ff] <= req_sample;
         total_ff         <= total_in;
         slot_ff          <= slot_in;
      end
   end

   // quotient estimate is exact or one short
   assign recip_prod = PROD_W'(total_ff) * PROD_W'(RECIP);
   assign qest_in    = recip_prod[ddma_pkg::RECIP_SHIFT +: ddma_pkg::SAMPLE_W];

   assign rem    = REM_W'(total_ff) - REM_W'(qest_ff) * REM_W'(WINDOW);
   assign avg_in = (rem >= REM_W'(WINDOW)) ? qest_ff + 1'b1 : qest_ff;

   // millivolts in q8: avg * full_scale / 16
   assign volt_prod = VPROD_W'(avg_ff) * VPROD_W'(full_scale_mv);
   assign volt_in   = volt_prod[VPROD_W-1:4];

   assign floor_q8  = {no_dust_mv, 8'd0};
   assign diff      = volt_ff - floor_q8;
   assign dens_prod = DPROD_W'(diff) * DPROD_W'(ratio_q16);
   // product >> 16 always fits in 24 bits, no saturation needed
   assign density_in = (volt_ff >= floor_q8) ? dens_prod[DPROD_W-1:ddma_pkg::CFG_W] : '0;

   always_ff @(posedge clock) begin
      if (cmd.div)  qest_ff <= qest_in;
      if (cmd.corr) avg_ff  <= avg_in;
      if (cmd.volt) volt_ff <= volt_in;
      if (cmd.load) begin
         density_ff <= density_in;
         average_ff <= avg_ff;
      end
   end

   assign rsp_density_q8 = density_ff;
   assign rsp_average    = average_ff;

endmodule

// ===== rtl/dust_density_moving_average.sv =====
// a result beat reaches rsp after the divide, correction, voltage multiply and
// density multiply steps run in turn on one datapath; a new beat is accepted only
// when idle or as the last one loads its result, which a stalled rsp holds back
// reset: synchronous, active high; clears the sample ring, running sum,
// write slot and handshake state, and loads the register defaults
module dust_density_moving_average #(
   parameter int WINDOW = ddma_pkg::WINDOW_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [ddma_pkg::SAMPLE_W-1:0]      req_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [ddma_pkg::DENSITY_W-1:0]     rsp_density_q8,
   output logic [ddma_pkg::SAMPLE_W-1:0]      rsp_average,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [ddma_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [ddma_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [ddma_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready
);

   ddma_pkg::ctrl_cmd_type cmd;

   logic [ddma_pkg::CFG_W-1:0] no_dust_ff;
   logic [ddma_pkg::CFG_W-1:0] ratio_ff;
   logic [ddma_pkg::CFG_W-1:0] full_scl_ff;
   logic [1:0]                 reg_idx;
   logic                       csr_wr;

   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];
   assign csr_wr  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         no_dust_ff  <= ddma_pkg::NO_DUST_RESET;
         ratio_ff    <= ddma_pkg::RATIO_RESET;
         full_scl_ff <= ddma_pkg::FULL_SCL_RESET;
      end else if (csr_wr) begin
         case (reg_idx)
            ddma_pkg::REG_NO_DUST:  no_dust_ff  <= pwdata[ddma_pkg::CFG_W-1:0];
            ddma_pkg::REG_RATIO:    ratio_ff    <= pwdata[ddma_pkg::CFG_W-1:0];
            ddma_pkg::REG_FULL_SCL: full_scl_ff <= pwdata[ddma_pkg::CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         ddma_pkg::REG_NO_DUST:  prdata = ddma_pkg::CSR_DATA_W'(no_dust_ff);
         ddma_pkg::REG_RATIO:    prdata = ddma_pkg::CSR_DATA_W'(ratio_ff);
         ddma_pkg::REG_FULL_SCL: prdata = ddma_pkg::CSR_DATA_W'(full_scl_ff);
         default:                prdata = '0;
      endcase
   end

   ddma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   ddma_dpath #(
      .WINDOW (WINDOW)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_sample     (req_sample),
      .no_dust_mv     (no_dust_ff),
      .ratio_q16      (ratio_ff),
      .full_scale_mv  (full_scl_ff),
      .rsp_density_q8 (rsp_density_q8),
      .rsp_average    (rsp_average)
   );

   // one beat in flight: an accepted beat blocks the next edge
   assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> req_stall)
      else $error("input accepted on consecutive cycles");

   // a rising result valid traces back to an accepted beat through the divide, correction, voltage and density steps
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.accept, 5))
      else $error("result without matching accepted beat");

   // a result is loaded only from the final step with the output free
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!rsp_valid || !rsp_stall))
      else $error("result register overwritten while stalled");

endmodule

// ===== dv/dust_density_moving_average_tb.sv =====
`timescale 1ns / 1ps

module dust_density_moving_average_tb;

   localparam int WIN_LEN     = ddma_pkg::WINDOW_DEFAULT;
   localparam int CYCLE_LIMIT = 300000;
   localparam logic [1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      logic [ddma_pkg::DENSITY_W-1:0] density_q8;
      logic [ddma_pkg::SAMPLE_W-1:0]  average;
   } reading_type;

   typedef enum int {SPREAD_FULL, SPREAD_LOW, SPREAD_RUNS} sample_spread_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [ddma_pkg::SAMPLE_W-1:0]   req_sample = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [ddma_pkg::DENSITY_W-1:0]  rsp_density_q8;
   logic [ddma_pkg::SAMPLE_W-1:0]   rsp_average;
   logic                            psel = 1'b0;
   logic                            penable = 1'b0;
   logic                            pwrite = 1'b0;
   logic [ddma_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [ddma_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [ddma_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;

   dust_density_moving_average #(.WINDOW(WIN_LEN)) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_density_q8 (rsp_density_q8),
      .rsp_average    (rsp_average),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state and register copies
   logic [ddma_pkg::CFG_W-1:0]    cfg_no_dust    = ddma_pkg::NO_DUST_RESET;
   logic [ddma_pkg::CFG_W-1:0]    cfg_ratio      = ddma_pkg::RATIO_RESET;
   logic [ddma_pkg::CFG_W-1:0]    cfg_full_scale = ddma_pkg::FULL_SCL_RESET;
   logic [ddma_pkg::SAMPLE_W-1:0] win_ring [WIN_LEN] = '{default: '0};
   logic [ddma_pkg::TOTAL_W-1:0]  win_total = '0;
   int                            win_slot  = 0;

   logic [ddma_pkg::SAMPLE_W-1:0] sample_backlog [$];
   reading_type                   pending_readings [$];
   int                            mismatch_count = 0;
   int                            cycle_count = 0;
   int                            req_idle_max = 10;
   int                            rsp_idle_max = 10;
   int                            req_wait = 0;
   int                            rsp_wait = 0;
   logic                          req_took = 1'b0;
   logic                          rsp_took = 1'b0;

   function automatic reading_type take_sample(input logic [ddma_pkg::SAMPLE_W-1:0] s);
      logic [27:0]                    scaled;
      logic [ddma_pkg::VOLT_W-1:0]    v_q8;
      logic [ddma_pkg::VOLT_W-1:0]    floor_q8;
      logic [39:0]                    prod;
      logic [39:0]                    dens;
      reading_type                    r;
      win_total = win_total - ddma_pkg::TOTAL_W'(win_ring[win_slot])
                + ddma_pkg::TOTAL_W'(s);
      win_ring[win_slot] = s;
      win_slot = (win_slot == WIN_LEN - 1) ? 0 : win_slot + 1;
      r.average = ddma_pkg::SAMPLE_W'(win_total / WIN_LEN);
      scaled = 28'(r.average) * 28'(cfg_full_scale);
      v_q8 = ddma_pkg::VOLT_W'(scaled >> 4);
      floor_q8 = {cfg_no_dust, 8'd0};
      r.density_q8 = '0;
      if (v_q8 >= floor_q8) begin
         prod = 40'(v_q8 - floor_q8) * 40'(cfg_ratio);
         dens = prod >> 16;
         r.density_q8 = (dens > 40'hFF_FFFF) ? '1 : dens[ddma_pkg::DENSITY_W-1:0];
      end
      return r;
   endfunction

   task automatic csr_write(input logic [1:0] idx, input logic [ddma_pkg::CFG_W-1:0] val);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = {idx, 2'b00};
      pwdata = {16'($urandom), val};
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         ddma_pkg::REG_NO_DUST:  cfg_no_dust = val;
         ddma_pkg::REG_RATIO:    cfg_ratio = val;
         ddma_pkg::REG_FULL_SCL: cfg_full_scale = val;
         default: ;
      endcase
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   function automatic logic [ddma_pkg::CFG_W-1:0] pick_cfg();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic queue_samples(input int count, input sample_spread_type spread);
      logic [ddma_pkg::SAMPLE_W-1:0] held;
      int                            run_left;
      held = '0;
      run_left = 0;
      for (int k = 0; k < count; k++) begin
         case (spread)
            SPREAD_FULL: sample_backlog.push_back(12'($urandom));
            SPREAD_LOW:  sample_backlog.push_back(12'($urandom_range(0, 255)));
            default: begin
               if (run_left == 0) begin
                  held = 12'($urandom);
                  run_left = $urandom_range(1, 15);
               end
               run_left--;
               sample_backlog.push_back(held);
            end
         endcase
      end
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (sample_backlog.size() != 0 || req_valid || pending_readings.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_wait <= 0;
      end else if (!req_valid || req_took) begin
         if (req_wait > 0) begin
            req_valid <= 1'b0;
            req_wait <= req_wait - 1;
         end else if (sample_backlog.size() != 0) begin
            req_sample <= sample_backlog.pop_front();
            req_valid <= 1'b1;
            req_wait <= $urandom_range(0, req_idle_max);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result stall, drawn once per beat and counted while valid is up
   always @(negedge clock) begin
      int hold;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait <= 0;
      end else if (rsp_took) begin
         hold = $urandom_range(0, rsp_idle_max);
         rsp_wait <= hold;
         rsp_stall <= (hold != 0);
      end else if (rsp_valid && rsp_wait > 0) begin
         rsp_wait <= rsp_wait - 1;
         rsp_stall <= (rsp_wait > 1);
      end
   end

   // sample both channels; check results before queueing new predictions
   always @(posedge clock) begin
      reading_type want;
      req_took <= !reset && req_valid && !req_stall;
      rsp_took <= !reset && rsp_valid && !rsp_stall;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_readings.size() == 0) begin
            $display("%0t: unexpected beat density_q8 %0d average %0d", $time,
                     rsp_density_q8, rsp_average);
            mismatch_count++;
         end else begin
            want = pending_readings.pop_front();
            if (rsp_density_q8 !== want.density_q8) begin
               $display("%0t: density_q8 expected %0d, got %0d", $time,
                        want.density_q8, rsp_density_q8);
               mismatch_count++;
            end
            if (rsp_average !== want.average) begin
               $display("%0t: average expected %0d, got %0d", $time,
                        want.average, rsp_average);
               mismatch_count++;
            end
         end
      end
      if (!reset && req_valid && !req_stall)
         pending_readings.push_back(take_sample(req_sample));
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int phase;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // defaults: clean air, full scale and alternating bit patterns
      sample_backlog.push_back(12'h000);
      sample_backlog.push_back(12'hFFF);
      sample_backlog.push_back(12'hAAA);
      sample_backlog.push_back(12'h555);
      repeat (8) sample_backlog.push_back(12'hFFF);
      wait_drained();

      // largest possible density
      csr_write(ddma_pkg::REG_NO_DUST, 16'h0000);
      csr_write(ddma_pkg::REG_RATIO, 16'hFFFF);
      csr_write(ddma_pkg::REG_FULL_SCL, 16'hFFFF);
      repeat (3) sample_backlog.push_back(12'hFFF);
      wait_drained();

      // zero scale, then zero ratio
      csr_write(ddma_pkg::REG_FULL_SCL, 16'h0000);
      repeat (2) sample_backlog.push_back(12'hFFF);
      wait_drained();
      csr_write(ddma_pkg::REG_FULL_SCL, 16'hFFFF);
      csr_write(ddma_pkg::REG_RATIO, 16'h0000);
      repeat (2) sample_backlog.push_back(12'hFFF);
      wait_drained();

      // write to an unmapped address must leave everything alone
      csr_write(ddma_pkg::REG_RATIO, ddma_pkg::RATIO_RESET);
      csr_write(REG_UNUSED, 16'h0000);
      sample_backlog.push_back(12'h800);
      repeat (2) sample_backlog.push_back(12'h000);
      wait_drained();

      for (phase = 0; phase < 8; phase++) begin
         csr_write(ddma_pkg::REG_FULL_SCL, pick_cfg());
         csr_write(ddma_pkg::REG_RATIO, pick_cfg());
         // keep the clean-air threshold inside the reachable range most of the time
         if ($urandom_range(0, 3) != 0)
            csr_write(ddma_pkg::REG_NO_DUST, 16'($urandom_range(0, cfg_full_scale)));
         else
            csr_write(ddma_pkg::REG_NO_DUST, pick_cfg());
         if ($urandom_range(0, 2) == 0)
            csr_write(REG_UNUSED, 16'($urandom));
         queue_samples(140, sample_spread_type'(phase % 3));
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/ddma_pkg.sv
rtl/ddma_ctrl.sv
rtl/ddma_dpath.sv
rtl/dust_density_moving_average.sv
dv/dust_density_moving_average_tb.sv
